// ===== sv/sha256_pkg.sv =====
// Package: shared types, constants and round functions for the SHA-256 hasher.
package sha256_pkg;

    localparam int unsigned NUM_ROUNDS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       comp_start;
        logic       comp_step;
        logic       add_hash;
        logic       restart;
        logic       bump_bits;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0]  fill;
        logic [5:0]  round;
        logic [63:0] bits;
    } t_dp_stat;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

endpackage

// ===== sv/sha256_if.sv =====
// Interfaces: valid/ready channels for input and digest transactions.
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

// ===== sv/sha256_datapath.sv =====
// Datapath: block buffer, message schedule window, round registers and hash words.
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [2:0]  i_word_sel,
    output t_dp_stat    o_stat,
    output logic [31:0] o_hash_word
);

    // block buffer as a byte shift register, first byte of the block ends up on top
    logic [511:0] r_blk, n_blk;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [63:0] r_bits;

    logic [31:0] w_cur, w_new, t1, t2, s0, s1;

    assign w_cur = r_w[0];
    assign s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_round) + w_cur;
    assign t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_blk = r_blk;
        if (i_cmd.load_byte) begin
            n_blk = {r_blk[503:0], i_cmd.byte_val};
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (i_cmd.comp_start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= n_blk[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.comp_step) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_h(3'(i));
            end
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.load_byte) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.bump_bits) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.comp_start) begin
                r_round <= '0;
            end else if (i_cmd.comp_step) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    assign o_stat.fill  = r_fill;
    assign o_stat.round = r_round;
    assign o_stat.bits  = r_bits;
    assign o_hash_word  = r_h[i_word_sel];

endmodule

// ===== sv/sha256_ctrl.sv =====
// Controller: sequences byte loads, padding, compression and digest output.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha256_in_if.sink   in_ch,
    sha256_out_if.source out_ch,
    input  t_dp_stat    i_stat,
    input  logic [31:0] i_hash_word,
    output t_dp_cmd     o_cmd,
    output logic [2:0]  o_word_sel
);

    t_state      r_state, n_state;
    logic        r_fin, n_fin;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_total, n_total;
    logic        in_fire, full_now;
    logic        r_emit;

    assign in_fire = in_ch.valid && (r_state == ST_IDLE);
    assign full_now = (i_stat.fill == 6'd63);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_idx   <= n_idx;
        end
        r_total <= n_total;
    end

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_idx   = r_idx;
        n_total = r_total;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_ch.op) begin
                        n_total = i_stat.bits;
                        n_fin   = 1'b1;
                        n_state = full_now ? ST_COMP : ST_PAD;
                    end else if (full_now) begin
                        n_fin   = 1'b0;
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD: begin
                if (i_stat.fill == 6'd55 || i_stat.fill == 6'd56) begin
                    n_idx   = '0;
                    n_state = ST_LEN;
                end else if (full_now) begin
                    n_state = ST_COMP;
                end
            end
            ST_LEN: begin
                n_idx = r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    n_fin   = 1'b0;
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (i_stat.round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_idx = '0;
                if (r_fin) begin
                    n_state = ST_PAD;
                end else if (r_emit) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_ch.ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // a finish chain ends in ST_LEN -> ST_COMP -> ST_ADD, flagged by r_emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (r_state == ST_LEN && r_idx == 3'd7) begin
            r_emit <= 1'b1;
        end else if (r_state == ST_ADD) begin
            r_emit <= 1'b0;
        end
    end

    always_comb begin
        o_cmd          = '0;
        in_ch.ready    = 1'b0;
        out_ch.valid   = 1'b0;
        o_word_sel     = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_fire) begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.byte_val  = in_ch.op ? 8'h80 : in_ch.data_byte;
                    o_cmd.bump_bits = !in_ch.op;
                end
            end
            ST_PAD: begin
                if (i_stat.fill != 6'd56) begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.byte_val  = 8'h00;
                end
            end
            ST_LEN: begin
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_val  = r_total[6'(8 * (7 - r_idx)) +: 8];
            end
            ST_COMP: begin
                o_cmd.comp_step = 1'b1;
            end
            ST_ADD: begin
                o_cmd.add_hash = 1'b1;
            end
            ST_EMIT: begin
                out_ch.valid = 1'b1;
                if (out_ch.ready && r_idx == 3'd7) begin
                    o_cmd.restart = 1'b1;
                end
            end
            default: ;
        endcase
        if (n_state == ST_COMP && r_state != ST_COMP) begin
            o_cmd.comp_start = 1'b1;
        end
    end

    logic r_first;
    always_ff @(posedge i_clk) begin
        r_first <= (r_state != ST_COMP);
    end

    assign out_ch.digest_word = i_hash_word;
    assign out_ch.word_index  = r_idx;
    assign out_ch.last_word   = (r_idx == 3'd7);

`ifndef SYNTH
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready) else $error("ready outside idle");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (r_state == ST_EMIT)) else $error("valid outside emit");
    a_comp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> $past(i_stat.round == 6'(NUM_ROUNDS - 1)))
        else $error("short compression");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_first) |-> (i_stat.round == 6'd0))
        else $error("round counter not cleared");
`endif

endmodule

// ===== sv/sha256_byte_stream_hasher_unit.sv =====
// Top level: SHA-256 hasher over a byte stream, controller plus datapath.
// Data transaction: a byte that fills a block starts a compression before the next byte is taken.
// Finish: loads 0x80, any zero bytes and 8 length bytes (with an idle step when no zero
// byte is needed), compresses each full block, then emits the 8 words as out_ch allows.
// Throughput is set by the single shared round unit: 64 rounds per block, one per cycle.
// Synchronous active-low reset loads the initial hash values and clears counts.
module sha256_byte_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [31:0] hash_word;
    logic [2:0]  word_sel;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_stat      (stat),
        .i_hash_word (hash_word),
        .o_cmd       (cmd),
        .o_word_sel  (word_sel)
    );

    sha256_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word_sel  (word_sel),
        .o_stat      (stat),
        .o_hash_word (hash_word)
    );

endmodule
